FILE: rtl/ppi_pkg.sv
// Shared widths, pipeline depths and word types for the plane-plane intersection unit.
package ppi_pkg;

	// field widths
	localparam int NrmW = 16;              // normals and direction, Q1.14
	localparam int PW = 32;                // positions, Q16.16
	localparam int SineW = 15;             // threshold register
	localparam int ThrShift = 28;          // threshold square to Q.56
	localparam int ThrW = 2 * SineW + ThrShift;
	localparam int DW = 50;                // plane offset d, Q.30
	localparam int SW = 64;                // squared cross length, Q.56
	localparam int LW = 32;                // cross length, Q.28
	localparam int DirFrac = 14;           // Q1.14 scaling of the direction
	localparam int QW = 15;                // direction quotient bits
	localparam int CW = LW + QW;           // direction divider remainder
	localparam int EW = 32;                // b x c and c x a terms
	localparam int TW = 50;                // determinant
	localparam int DH = 25;                // split point of d for the wide products
	localparam int NW = 84;                // point numerator
	localparam int RW = NW + 2;            // point divider remainder

	// saturation limits of a position word
	localparam logic [PW-1:0] PosMax = {1'b0, {(PW-1){1'b1}}};
	localparam logic [PW-1:0] NegMin = {1'b1, {(PW-1){1'b0}}};

	// stage counts of each unit
	localparam int FrontDepth = 5;
	localparam int SqrtDepth = LW;
	localparam int CdivDepth = QW + 2;
	localparam int SolveDepth = 5;
	localparam int QdivDepth = PW + 4;
	localparam int Latency = FrontDepth + SqrtDepth + CdivDepth + SolveDepth + QdivDepth;

	typedef logic [2:0][NrmW-1:0] nvec_t;
	typedef logic [2:0][PW-1:0] pvec_t;

	// plane pair after offsets and cross product
	typedef struct packed {
		nvec_t a;
		nvec_t b;
		logic [DW-1:0] d1;
		logic [DW-1:0] d2;
		logic [2:0][LW-1:0] wmag;
		logic [2:0] wneg;
		logic [SW-1:0] s;
		logic par;
	} geo_t;

	// solved system ready for the point divider
	typedef struct packed {
		logic [2:0][NW-1:0] num;
		logic [TW-1:0] det;
		nvec_t c;
		logic bad;
	} sol_t;

	// result word
	typedef struct packed {
		logic ok;
		nvec_t dir;
		pvec_t pt;
	} res_t;

endpackage

FILE: rtl/ppi_front.sv
// Front stages: plane offsets, cross product of the normals, squared length and parallel test.
module ppi_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ppi_pkg::nvec_t a,
	input  ppi_pkg::pvec_t p,
	input  ppi_pkg::nvec_t b,
	input  ppi_pkg::pvec_t q,
	input  logic [ppi_pkg::ThrW-1:0] thr,
	output logic out_valid,
	output ppi_pkg::geo_t geo
);
	localparam int DW = ppi_pkg::DW;
	localparam int LW = ppi_pkg::LW;
	localparam int SW = ppi_pkg::SW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ppi_pkg::nvec_t a_s1, b_s1, a_s2, b_s2, a_s3, b_s3, a_s4, b_s4, a_s5, b_s5;
	ppi_pkg::pvec_t p_s1, q_s1;
	logic signed [47:0] ap_s2 [3];
	logic signed [47:0] bq_s2 [3];
	logic signed [31:0] cr_s2 [6];
	logic signed [DW-1:0] d1_s3, d2_s3;
	logic [DW-1:0] d1_s4, d2_s4, d1_s5, d2_s5;
	logic [2:0][LW-1:0] wmag_s3, wmag_s4, wmag_s5;
	logic [2:0] wneg_s3, wneg_s4, wneg_s5;
	logic [SW-1:0] sq_s4 [3];
	logic [SW-1:0] s_s5;
	logic par_s5;
	logic signed [32:0] w3 [3];
	logic signed [32:0] wabs [3];
	logic [SW-1:0] s_sum;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// cross product differences and magnitudes
	assign w3[0] = cr_s2[0] - cr_s2[1];
	assign w3[1] = cr_s2[2] - cr_s2[3];
	assign w3[2] = cr_s2[4] - cr_s2[5];
	for (genvar i = 0; i < 3; i++) begin : g_abs
		assign wabs[i] = w3[i][32] ? -w3[i] : w3[i];
	end

	assign s_sum = sq_s4[0] + sq_s4[1] + sq_s4[2];

	// datapath
	always_ff @(posedge clk) begin
		a_s1 <= a;
		b_s1 <= b;
		p_s1 <= p;
		q_s1 <= q;
		// stage 2: products
		for (int i = 0; i < 3; i++) begin
			ap_s2[i] <= $signed(a_s1[i]) * $signed(p_s1[i]);
			bq_s2[i] <= $signed(b_s1[i]) * $signed(q_s1[i]);
		end
		cr_s2[0] <= $signed(a_s1[1]) * $signed(b_s1[2]);
		cr_s2[1] <= $signed(a_s1[2]) * $signed(b_s1[1]);
		cr_s2[2] <= $signed(a_s1[2]) * $signed(b_s1[0]);
		cr_s2[3] <= $signed(a_s1[0]) * $signed(b_s1[2]);
		cr_s2[4] <= $signed(a_s1[0]) * $signed(b_s1[1]);
		cr_s2[5] <= $signed(a_s1[1]) * $signed(b_s1[0]);
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		// stage 3: offsets and cross product
		d1_s3 <= ap_s2[0] + ap_s2[1] + ap_s2[2];
		d2_s3 <= bq_s2[0] + bq_s2[1] + bq_s2[2];
		for (int i = 0; i < 3; i++) begin
			wmag_s3[i] <= wabs[i][LW-1:0];
			wneg_s3[i] <= w3[i][32];
		end
		a_s3 <= a_s2;
		b_s3 <= b_s2;
		// stage 4: squares
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= SW'(wmag_s3[i]) * SW'(wmag_s3[i]);
		end
		d1_s4 <= d1_s3;
		d2_s4 <= d2_s3;
		wmag_s4 <= wmag_s3;
		wneg_s4 <= wneg_s3;
		a_s4 <= a_s3;
		b_s4 <= b_s3;
		// stage 5: squared length and parallel test
		s_s5 <= s_sum;
		par_s5 <= (s_sum < SW'(thr)) || (s_sum == '0);
		d1_s5 <= d1_s4;
		d2_s5 <= d2_s4;
		wmag_s5 <= wmag_s4;
		wneg_s5 <= wneg_s4;
		a_s5 <= a_s4;
		b_s5 <= b_s4;
	end

	assign out_valid = v_s5;
	assign geo.a = a_s5;
	assign geo.b = b_s5;
	assign geo.d1 = d1_s5;
	assign geo.d2 = d2_s5;
	assign geo.wmag = wmag_s5;
	assign geo.wneg = wneg_s5;
	assign geo.s = s_s5;
	assign geo.par = par_s5;

endmodule

FILE: rtl/ppi_sqrt.sv
// Pipelined integer square root of the squared cross length, one root bit per stage.
module ppi_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ppi_pkg::geo_t geo_in,
	output logic out_valid,
	output logic [ppi_pkg::LW-1:0] len,
	output ppi_pkg::geo_t geo_out
);
	localparam int LW = ppi_pkg::LW;
	localparam int SW = ppi_pkg::SW;

	logic [SW-1:0] rem_s [LW];
	logic [LW-1:0] root_s [LW];
	logic v_s [LW];
	ppi_pkg::geo_t g_s [LW];

	for (genvar j = 0; j < LW; j++) begin : g_stg
		localparam int K = LW - 1 - j;
		logic [SW-1:0] rem_i;
		logic [LW-1:0] root_i;
		logic v_i;
		ppi_pkg::geo_t g_i;
		logic [SW+1:0] trial;
		logic ge;

		if (j == 0) begin : g_in
			assign rem_i = geo_in.s;
			assign root_i = '0;
			assign v_i = in_valid;
			assign g_i = geo_in;
		end else begin : g_prev
			assign rem_i = rem_s[j-1];
			assign root_i = root_s[j-1];
			assign v_i = v_s[j-1];
			assign g_i = g_s[j-1];
		end

		// (r + 2^K)^2 - r^2, with r holding only bits above K
		assign trial = ((SW+2)'(root_i) << (K + 1)) | ((SW+2)'(1) << (2 * K));
		assign ge = (SW+2)'(rem_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else v_s[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? rem_i - trial[SW-1:0] : rem_i;
			root_s[j] <= ge ? (root_i | (LW'(1) << K)) : root_i;
			g_s[j] <= g_i;
		end
	end

	assign out_valid = v_s[LW-1];
	assign len = root_s[LW-1];
	assign geo_out = g_s[LW-1];

	// root is the floor square root of its operand
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((SW+2)'(len) * (SW+2)'(len) <= (SW+2)'(geo_out.s)) &&
			(((SW+2)'(len) + 1) * ((SW+2)'(len) + 1) > (SW+2)'(geo_out.s)))
		else $error("square root out of bounds");

endmodule

FILE: rtl/ppi_cdiv.sv
// Direction normalization: three lanes of rounded cross component over length, restoring divide.
module ppi_cdiv (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [ppi_pkg::LW-1:0] len,
	input  ppi_pkg::geo_t geo_in,
	output logic out_valid,
	output ppi_pkg::nvec_t c,
	output ppi_pkg::geo_t geo_out
);
	localparam int LW = ppi_pkg::LW;
	localparam int QW = ppi_pkg::QW;
	localparam int CW = ppi_pkg::CW;
	localparam int NrmW = ppi_pkg::NrmW;

	logic v_s1;
	logic [2:0][CW-1:0] n_s1;
	logic [LW-1:0] len_s1;
	ppi_pkg::geo_t g_s1;

	logic [2:0][CW-1:0] rem_s [QW];
	logic [2:0][QW-1:0] q_s [QW];
	logic [LW-1:0] len_s [QW];
	logic v_s [QW];
	ppi_pkg::geo_t g_s [QW];

	logic v_sn;
	ppi_pkg::nvec_t c_sn;
	ppi_pkg::geo_t g_sn;

	// rounded numerators: |w| * 2^14 + len / 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			n_s1[i] <= (CW'(geo_in.wmag[i]) << ppi_pkg::DirFrac) + CW'(len >> 1);
		end
		len_s1 <= len;
		g_s1 <= geo_in;
	end

	// one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_stg
		localparam int K = QW - 1 - j;
		logic [2:0][CW-1:0] rem_i;
		logic [2:0][QW-1:0] q_i;
		logic [LW-1:0] len_i;
		logic v_i;
		ppi_pkg::geo_t g_i;
		logic [CW-1:0] trial;

		if (j == 0) begin : g_in
			assign rem_i = n_s1;
			assign q_i = '0;
			assign len_i = len_s1;
			assign v_i = v_s1;
			assign g_i = g_s1;
		end else begin : g_prev
			assign rem_i = rem_s[j-1];
			assign q_i = q_s[j-1];
			assign len_i = len_s[j-1];
			assign v_i = v_s[j-1];
			assign g_i = g_s[j-1];
		end

		assign trial = CW'(len_i) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else v_s[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_i[i] >= trial) begin
					rem_s[j][i] <= rem_i[i] - trial;
					q_s[j][i] <= q_i[i] | (QW'(1) << K);
				end else begin
					rem_s[j][i] <= rem_i[i];
					q_s[j][i] <= q_i[i];
				end
			end
			len_s[j] <= len_i;
			g_s[j] <= g_i;
		end
	end

	// restore the sign of each component
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sn <= 1'b0;
		else v_sn <= v_s[QW-1];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c_sn[i] <= g_s[QW-1].wneg[i] ? NrmW'(-NrmW'(q_s[QW-1][i]))
				: NrmW'(q_s[QW-1][i]);
		end
		g_sn <= g_s[QW-1];
	end

	assign out_valid = v_sn;
	assign c = c_sn;
	assign geo_out = g_sn;

	// a unit direction never exceeds one in any component
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !geo_out.par |->
			($signed(c[0]) <= 16384) && ($signed(c[0]) >= -16384) &&
			($signed(c[1]) <= 16384) && ($signed(c[1]) >= -16384) &&
			($signed(c[2]) <= 16384) && ($signed(c[2]) >= -16384))
		else $error("direction component above one");

endmodule

FILE: rtl/ppi_solve.sv
// Cramer solve: b x c, c x a, determinant and the wide point numerators.
module ppi_solve (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ppi_pkg::nvec_t c,
	input  ppi_pkg::geo_t geo_in,
	output logic out_valid,
	output ppi_pkg::sol_t sol
);
	localparam int DW = ppi_pkg::DW;
	localparam int DH = ppi_pkg::DH;
	localparam int EW = ppi_pkg::EW;
	localparam int TW = ppi_pkg::TW;
	localparam int NW = ppi_pkg::NW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ppi_pkg::nvec_t c_s1, c_s2, c_s3, c_s4, c_s5;
	ppi_pkg::nvec_t a_s1, a_s2;
	logic [DW-1:0] d1_s1, d2_s1, d1_s2, d2_s2;
	logic par_s1, par_s2, par_s3, par_s4;
	logic signed [EW-1:0] pe_s1 [6];
	logic signed [EW-1:0] pf_s1 [6];
	logic signed [EW-1:0] e_s2 [3];
	logic signed [EW-1:0] f_s2 [3];
	logic signed [47:0] ae_s3 [3];
	logic signed [DW-DH+EW-1:0] eh_s3 [3];
	logic signed [DH+EW:0] el_s3 [3];
	logic signed [DW-DH+EW-1:0] fh_s3 [3];
	logic signed [DH+EW:0] fl_s3 [3];
	logic signed [TW-1:0] det_s4;
	logic signed [NW-1:0] pn_s4 [3];
	logic signed [NW-1:0] pm_s4 [3];
	logic [TW-1:0] det_s5;
	logic [2:0][NW-1:0] num_s5;
	logic bad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: cross product terms
		pe_s1[0] <= $signed(geo_in.b[1]) * $signed(c[2]);
		pe_s1[1] <= $signed(geo_in.b[2]) * $signed(c[1]);
		pe_s1[2] <= $signed(geo_in.b[2]) * $signed(c[0]);
		pe_s1[3] <= $signed(geo_in.b[0]) * $signed(c[2]);
		pe_s1[4] <= $signed(geo_in.b[0]) * $signed(c[1]);
		pe_s1[5] <= $signed(geo_in.b[1]) * $signed(c[0]);
		pf_s1[0] <= $signed(c[1]) * $signed(geo_in.a[2]);
		pf_s1[1] <= $signed(c[2]) * $signed(geo_in.a[1]);
		pf_s1[2] <= $signed(c[2]) * $signed(geo_in.a[0]);
		pf_s1[3] <= $signed(c[0]) * $signed(geo_in.a[2]);
		pf_s1[4] <= $signed(c[0]) * $signed(geo_in.a[1]);
		pf_s1[5] <= $signed(c[1]) * $signed(geo_in.a[0]);
		c_s1 <= c;
		a_s1 <= geo_in.a;
		d1_s1 <= geo_in.d1;
		d2_s1 <= geo_in.d2;
		par_s1 <= geo_in.par;
		// stage 2: e = b x c, f = c x a
		for (int i = 0; i < 3; i++) begin
			e_s2[i] <= pe_s1[2*i] - pe_s1[2*i+1];
			f_s2[i] <= pf_s1[2*i] - pf_s1[2*i+1];
		end
		c_s2 <= c_s1;
		a_s2 <= a_s1;
		d1_s2 <= d1_s1;
		d2_s2 <= d2_s1;
		par_s2 <= par_s1;
		// stage 3: determinant terms and split numerator products
		for (int i = 0; i < 3; i++) begin
			ae_s3[i] <= $signed(a_s2[i]) * e_s2[i];
			eh_s3[i] <= $signed(d1_s2[DW-1:DH]) * e_s2[i];
			el_s3[i] <= $signed({1'b0, d1_s2[DH-1:0]}) * e_s2[i];
			fh_s3[i] <= $signed(d2_s2[DW-1:DH]) * f_s2[i];
			fl_s3[i] <= $signed({1'b0, d2_s2[DH-1:0]}) * f_s2[i];
		end
		c_s3 <= c_s2;
		par_s3 <= par_s2;
		// stage 4: determinant, d1*e and d2*f
		det_s4 <= ae_s3[0] + ae_s3[1] + ae_s3[2];
		for (int i = 0; i < 3; i++) begin
			pn_s4[i] <= (NW'(eh_s3[i]) <<< DH) + NW'(el_s3[i]);
			pm_s4[i] <= (NW'(fh_s3[i]) <<< DH) + NW'(fl_s3[i]);
		end
		c_s4 <= c_s3;
		par_s4 <= par_s3;
		// stage 5: numerators and the invalid flag
		for (int i = 0; i < 3; i++) begin
			num_s5[i] <= pn_s4[i] + pm_s4[i];
		end
		det_s5 <= det_s4;
		bad_s5 <= par_s4 || (det_s4 <= 0);
		c_s5 <= c_s4;
	end

	assign out_valid = v_s5;
	assign sol.num = num_s5;
	assign sol.det = det_s5;
	assign sol.c = c_s5;
	assign sol.bad = bad_s5;

endmodule

FILE: rtl/ppi_qdiv.sv
// Point divider: rounded signed numerator over determinant, restoring, with saturation.
module ppi_qdiv (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ppi_pkg::sol_t sol,
	output logic out_valid,
	output ppi_pkg::res_t res
);
	localparam int NW = ppi_pkg::NW;
	localparam int RW = ppi_pkg::RW;
	localparam int TW = ppi_pkg::TW;
	localparam int PW = ppi_pkg::PW;

	// word riding along the divider
	typedef struct packed {
		logic [TW-1:0] dv;
		logic [2:0] neg;
		logic [2:0] over;
		ppi_pkg::nvec_t c;
		logic bad;
	} side_t;

	logic v_s1, v_s2, v_s3;
	logic [2:0][NW-1:0] mag_s1;
	logic [2:0][RW-1:0] n_s2, rem_s3;
	side_t sd_s1, sd_s2, sd_s3;

	logic [2:0][RW-1:0] rem_s [PW];
	logic [2:0][PW-1:0] q_s [PW];
	logic v_s [PW];
	side_t sd_s [PW];

	logic v_sn;
	ppi_pkg::res_t res_sn;
	ppi_pkg::pvec_t pt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: magnitudes
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= sol.num[i][NW-1] ? NW'(-sol.num[i]) : sol.num[i];
		end
		sd_s1.dv <= sol.det;
		sd_s1.neg <= {sol.num[2][NW-1], sol.num[1][NW-1], sol.num[0][NW-1]};
		sd_s1.over <= '0;
		sd_s1.c <= sol.c;
		sd_s1.bad <= sol.bad;
		// stage 2: add half the divisor for rounding
		for (int i = 0; i < 3; i++) begin
			n_s2[i] <= RW'(mag_s1[i]) + RW'(sd_s1.dv >> 1);
		end
		sd_s2 <= sd_s1;
		// stage 3: quotient beyond the word range
		for (int i = 0; i < 3; i++) begin
			sd_s3.over[i] <= n_s2[i] >= (RW'(sd_s2.dv) << PW);
		end
		rem_s3 <= n_s2;
		sd_s3.dv <= sd_s2.dv;
		sd_s3.neg <= sd_s2.neg;
		sd_s3.c <= sd_s2.c;
		sd_s3.bad <= sd_s2.bad;
	end

	// one quotient bit per stage
	for (genvar j = 0; j < PW; j++) begin : g_stg
		localparam int K = PW - 1 - j;
		logic [2:0][RW-1:0] rem_i;
		logic [2:0][PW-1:0] q_i;
		logic v_i;
		side_t sd_i;
		logic [RW-1:0] trial;

		if (j == 0) begin : g_in
			assign rem_i = rem_s3;
			assign q_i = '0;
			assign v_i = v_s3;
			assign sd_i = sd_s3;
		end else begin : g_prev
			assign rem_i = rem_s[j-1];
			assign q_i = q_s[j-1];
			assign v_i = v_s[j-1];
			assign sd_i = sd_s[j-1];
		end

		assign trial = RW'(sd_i.dv) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else v_s[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_i[i] >= trial) begin
					rem_s[j][i] <= rem_i[i] - trial;
					q_s[j][i] <= q_i[i] | (PW'(1) << K);
				end else begin
					rem_s[j][i] <= rem_i[i];
					q_s[j][i] <= q_i[i];
				end
			end
			sd_s[j] <= sd_i;
		end
	end

	// sign and saturation
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sd_s[PW-1].neg[i]) begin
				if (sd_s[PW-1].over[i] || (q_s[PW-1][i] > ppi_pkg::NegMin)) pt_nx[i] = ppi_pkg::NegMin;
				else pt_nx[i] = PW'(-q_s[PW-1][i]);
			end else begin
				if (sd_s[PW-1].over[i] || q_s[PW-1][i][PW-1]) pt_nx[i] = ppi_pkg::PosMax;
				else pt_nx[i] = q_s[PW-1][i];
			end
		end
	end

	// result register, cleared fields for parallel pairs and non-positive determinants
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sn <= 1'b0;
		else v_sn <= v_s[PW-1];
	end

	always_ff @(posedge clk) begin
		res_sn.ok <= !sd_s[PW-1].bad;
		res_sn.dir <= sd_s[PW-1].bad ? '0 : sd_s[PW-1].c;
		res_sn.pt <= sd_s[PW-1].bad ? '0 : pt_nx;
	end

	assign out_valid = v_sn;
	assign res = res_sn;

	// an invalid result carries all-zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !res.ok |-> (res.dir == '0) && (res.pt == '0))
		else $error("invalid result with nonzero fields");

endmodule

FILE: rtl/plane_plane_intersection_unit.sv
// Top level of the plane-plane intersection unit: threshold register and pipeline chain.
//
// Channel | Ports                                   | Transfer
// input   | start, busy, first_*, second_*          | word taken when start && !busy
// config  | cfg_valid, cfg_ready, cfg_data          | write when cfg_valid && cfg_ready
// result  | done, line_valid, line_dir_*, line_point_* | word shown for the cycle done is high
//
// A new plane pair may enter every cycle while busy is low.
// Depth is set by the 32-stage square root and the 32 quotient stages of the point divider,
// plus the 15 quotient stages of the direction divider and the product, rounding and sign stages.
// busy is high while reset is applied and is registered low at the next clock after; then it stays low.
// The result side has no back-pressure; cfg_ready is always high.
module plane_plane_intersection_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ppi_pkg::SineW-1:0] cfg_data,
	input  logic [15:0] first_normal_x,
	input  logic [15:0] first_normal_y,
	input  logic [15:0] first_normal_z,
	input  logic [31:0] first_point_x,
	input  logic [31:0] first_point_y,
	input  logic [31:0] first_point_z,
	input  logic [15:0] second_normal_x,
	input  logic [15:0] second_normal_y,
	input  logic [15:0] second_normal_z,
	input  logic [31:0] second_point_x,
	input  logic [31:0] second_point_y,
	input  logic [31:0] second_point_z,
	output logic done,
	output logic line_valid,
	output logic [15:0] line_dir_x,
	output logic [15:0] line_dir_y,
	output logic [15:0] line_dir_z,
	output logic [31:0] line_point_x,
	output logic [31:0] line_point_y,
	output logic [31:0] line_point_z
);
	localparam int SineW = ppi_pkg::SineW;
	localparam int ThrShift = ppi_pkg::ThrShift;

	logic busy_q;
	logic [2*SineW-1:0] sq_q;
	logic accept;
	ppi_pkg::nvec_t a_in, b_in;
	ppi_pkg::pvec_t p_in, q_in;

	logic f_valid, r_valid, c_valid, s_valid;
	ppi_pkg::geo_t f_geo, r_geo, c_geo;
	logic [ppi_pkg::LW-1:0] r_len;
	ppi_pkg::nvec_t c_dir;
	ppi_pkg::sol_t s_sol;
	ppi_pkg::res_t res;

	// busy through reset; threshold kept squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			sq_q <= (2*SineW)'(1);
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) sq_q <= (2*SineW)'(cfg_data) * (2*SineW)'(cfg_data);
		end
	end

	assign busy = busy_q;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy_q;

	assign a_in = {first_normal_z, first_normal_y, first_normal_x};
	assign p_in = {first_point_z, first_point_y, first_point_x};
	assign b_in = {second_normal_z, second_normal_y, second_normal_x};
	assign q_in = {second_point_z, second_point_y, second_point_x};

	ppi_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept),
		.a(a_in), .p(p_in), .b(b_in), .q(q_in),
		.thr({sq_q, {ThrShift{1'b0}}}),
		.out_valid(f_valid), .geo(f_geo)
	);

	ppi_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .geo_in(f_geo),
		.out_valid(r_valid), .len(r_len), .geo_out(r_geo)
	);

	ppi_cdiv u_cdiv (
		.clk(clk), .arst_n(arst_n), .in_valid(r_valid), .len(r_len), .geo_in(r_geo),
		.out_valid(c_valid), .c(c_dir), .geo_out(c_geo)
	);

	ppi_solve u_solve (
		.clk(clk), .arst_n(arst_n), .in_valid(c_valid), .c(c_dir), .geo_in(c_geo),
		.out_valid(s_valid), .sol(s_sol)
	);

	ppi_qdiv u_qdiv (
		.clk(clk), .arst_n(arst_n), .in_valid(s_valid), .sol(s_sol),
		.out_valid(done), .res(res)
	);

	assign line_valid = res.ok;
	assign line_dir_x = res.dir[0];
	assign line_dir_y = res.dir[1];
	assign line_dir_z = res.dir[2];
	assign line_point_x = res.pt[0];
	assign line_point_y = res.pt[1];
	assign line_point_z = res.pt[2];

	// every result word comes from a word taken at the input, as set by ppi_pkg::Latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, ppi_pkg::Latency))
		else $error("result without matching input word");

	// threshold write lands as its square
	a_thr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=>
			sq_q == (2*SineW)'($past(cfg_data)) * (2*SineW)'($past(cfg_data)))
		else $error("threshold register not updated");

endmodule
